FILE: rtl/core/ntl_pkg.sv
// types, constants and codes shared by the nearest-timestamp lookup block
// no dependencies
package ntl_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int TIME_W      = 32;
  localparam int FUNC_W      = 2;
  localparam int EIDX_W      = 10;
  localparam int STAT_W      = 2;
  localparam int CMP_W       = (CNT_W > EIDX_W) ? CNT_W : EIDX_W;

  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR   = 2'd0,
    FN_APPEND  = 2'd1,
    FN_NEAREST = 2'd2,
    FN_READ    = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_WAIT,
    S_SRCH,
    S_NB_LO,
    S_NB_HI,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [EIDX_W-1:0] found_index;
    logic [TIME_W-1:0] found_time;
    status_t           status;
    logic [TIME_W-1:0] duration_ms;
  } rslt_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [TIME_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } ram_req_t;

endpackage

FILE: rtl/core/ntl_if.sv
// request and response channel interfaces (valid/ready handshake)
// depends on ntl_pkg
interface ntl_req_if;
  import ntl_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [TIME_W-1:0] time_ms;
  logic [EIDX_W-1:0] entry_index;

  modport source (output valid, func, time_ms, entry_index, input ready);
  modport sink (input valid, func, time_ms, entry_index, output ready);
endinterface

interface ntl_rsp_if;
  import ntl_pkg::*;
  logic              valid;
  logic              ready;
  logic [EIDX_W-1:0] found_index;
  logic [TIME_W-1:0] found_time;
  logic [STAT_W-1:0] status;
  logic [TIME_W-1:0] duration_ms;

  modport source (output valid, found_index, found_time, status, duration_ms, input ready);
  modport sink (input valid, found_index, found_time, status, duration_ms, output ready);
endinterface

FILE: rtl/core/ntl_ram.sv
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module ntl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/ntl_ctrl.sv
// sequencer for clear, append, read and lower-bound search over the table ram
// depends on ntl_pkg
module ntl_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ntl_pkg::FUNC_W-1:0] func,
  input  logic [ntl_pkg::TIME_W-1:0] time_ms,
  input  logic [ntl_pkg::EIDX_W-1:0] entry_index,
  output ntl_pkg::ram_req_t         ram_req,
  input  logic [ntl_pkg::TIME_W-1:0] rdata,
  output logic                      rslt_valid,
  input  logic                      out_free,
  output ntl_pkg::rslt_t            rslt
);
  import ntl_pkg::*;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [TIME_W-1:0] dur, dur_next;
  logic [TIME_W-1:0] query, query_next;
  logic [CNT_W-1:0]  lo, lo_next;
  logic [CNT_W-1:0]  len, len_next;
  logic [CNT_W-1:0]  mid, mid_next;
  logic [TIME_W-1:0] nb_lo, nb_lo_next;
  logic [CMP_W-1:0]  f_idx, f_idx_next;
  logic [TIME_W-1:0] f_time, f_time_next;
  status_t           status, status_next;

  // search step terms
  logic [CNT_W-1:0]  half, s_lo, s_len;
  logic [TIME_W-1:0] dist_before, dist_after;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      dur   <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      dur   <= dur_next;
    end
  end

  always_ff @(posedge clk) begin
    query  <= query_next;
    lo     <= lo_next;
    len    <= len_next;
    mid    <= mid_next;
    nb_lo  <= nb_lo_next;
    f_idx  <= f_idx_next;
    f_time <= f_time_next;
    status <= status_next;
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    dur_next    = dur;
    query_next  = query;
    lo_next     = lo;
    len_next    = len;
    mid_next    = mid;
    nb_lo_next  = nb_lo;
    f_idx_next  = f_idx;
    f_time_next = f_time;
    status_next = status;
    ram_req     = '0;
    in_ready    = (state == S_IDLE);
    half        = len >> 1;
    s_lo        = lo;
    s_len       = half;
    dist_before = query - nb_lo;
    dist_after  = rdata - query;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          f_idx_next  = '0;
          f_time_next = '0;
          status_next = ST_OK;
          state_next  = S_DONE;
          unique case (func_t'(func))
            FN_CLEAR: begin
              count_next = '0;
              dur_next   = '0;
            end
            FN_APPEND: begin
              if (count == CNT_W'(MAX_ENTRIES)) begin
                status_next = ST_FULL;
              end else begin
                ram_req.we    = 1'b1;
                ram_req.waddr = count[IDX_W-1:0];
                ram_req.wdata = time_ms;
                f_idx_next    = CMP_W'(count);
                f_time_next   = time_ms;
                count_next    = count + 1'b1;
                dur_next      = time_ms;
              end
            end
            FN_NEAREST: begin
              query_next = time_ms;
              if (count == '0) begin
                status_next = ST_EMPTY;
              end else begin
                lo_next       = '0;
                len_next      = count;
                mid_next      = count >> 1;
                ram_req.raddr = mid_next[IDX_W-1:0];
                state_next    = S_SRCH;
              end
            end
            FN_READ: begin
              f_idx_next = CMP_W'(entry_index);
              if (CMP_W'(entry_index) >= CMP_W'(count)) begin
                status_next = ST_RANGE;
              end else begin
                ram_req.raddr = IDX_W'(entry_index);
                state_next    = S_RD_WAIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD_WAIT: begin
        f_time_next = rdata;
        state_next  = S_DONE;
      end
      S_SRCH: begin
        // rdata holds table[mid]
        if (rdata < query) begin
          s_lo  = mid + 1'b1;
          s_len = len - half - 1'b1;
        end
        lo_next  = s_lo;
        len_next = s_len;
        if (s_len != '0) begin
          mid_next      = s_lo + (s_len >> 1);
          ram_req.raddr = mid_next[IDX_W-1:0];
        end else if (s_lo >= count) begin
          // past the end: last entry, which is the duration
          f_idx_next  = CMP_W'(count - 1'b1);
          f_time_next = dur;
          state_next  = S_DONE;
        end else if (s_lo == '0) begin
          f_idx_next    = '0;
          ram_req.raddr = '0;
          state_next    = S_RD_WAIT;
        end else begin
          ram_req.raddr = IDX_W'(s_lo - 1'b1);
          state_next    = S_NB_LO;
        end
      end
      S_NB_LO: begin
        nb_lo_next    = rdata;
        ram_req.raddr = lo[IDX_W-1:0];
        state_next    = S_NB_HI;
      end
      S_NB_HI: begin
        // ties go to the earlier entry
        if (dist_before <= dist_after) begin
          f_idx_next  = CMP_W'(lo - 1'b1);
          f_time_next = nb_lo;
        end else begin
          f_idx_next  = CMP_W'(lo);
          f_time_next = rdata;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign rslt_valid       = (state == S_DONE);
  assign rslt.found_index = EIDX_W'(f_idx);
  assign rslt.found_time  = f_time;
  assign rslt.status      = status;
  assign rslt.duration_ms = dur;

endmodule

FILE: rtl/core/nearest_timestamp_lookup.sv
// top level of the nearest-timestamp lookup block: sequencer, table ram, result register
// depends on ntl_pkg, ntl_if, ntl_ram and ntl_ctrl
//
// Keeps up to MAX_ENTRIES 32-bit timestamps in one synchronous ram and takes
// one request transaction at a time: clear, append, nearest lookup or read at
// index, each giving exactly one response transaction. Clear, append and any
// request that is answered at once (full table, empty table, index out of
// range) go from the idle state straight to the done state; a read in range
// passes through a read-wait state first. A nearest lookup does a lower-bound
// binary search with one ram read per cycle (registered read data compared
// and the next address formed in the same cycle), followed by one more read
// when the first entry is picked and two more reads when both neighbours must
// be compared. The single ram read port sets the length of the search. The
// table needs no clearing after reset; only positions below the entry count
// are ever used. Appends are not checked for order. The response sits in its
// own register, so a new request is taken while the previous response waits
// to be collected.
module nearest_timestamp_lookup (
  input logic      clk,
  input logic      rst,
  ntl_req_if.sink  req,
  ntl_rsp_if.source rsp
);
  import ntl_pkg::*;

  ram_req_t          ram_req;
  logic [TIME_W-1:0] rdata;
  rslt_t             rslt;
  logic              rslt_valid;
  logic              out_free;
  logic              out_valid;
  rslt_t             out_reg;

  // output slot is free when empty or being drained this cycle
  assign out_free = !out_valid || rsp.ready;

  ntl_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .func        (req.func),
    .time_ms     (req.time_ms),
    .entry_index (req.entry_index),
    .ram_req     (ram_req),
    .rdata       (rdata),
    .rslt_valid  (rslt_valid),
    .out_free    (out_free),
    .rslt        (rslt)
  );

  // timestamp table
  ntl_ram #(
    .WIDTH (TIME_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (rdata)
  );

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= rslt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && rslt_valid) begin
      out_reg <= rslt;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.found_index = out_reg.found_index;
  assign rsp.found_time  = out_reg.found_time;
  assign rsp.status      = out_reg.status;
  assign rsp.duration_ms = out_reg.duration_ms;

endmodule
